>>> sv/ttu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttu_pkg: shared types and constants for the tag text transcoder
// Text encodings, stop causes, register indexes and the decode event that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ttu_pkg;

	typedef enum logic [1:0] {
		ENC_LATIN1  = 2'd0,
		ENC_UTF16LE = 2'd1,
		ENC_UTF16BE = 2'd2,
		ENC_UTF8    = 2'd3
	} enc_t;

	typedef enum logic [1:0] {
		CAUSE_END     = 2'd0,
		CAUSE_NUL     = 2'd1,
		CAUSE_INVALID = 2'd2,
		CAUSE_FULL    = 2'd3
	} cause_t;

	typedef enum logic {
		REG_TEXT_ENCODING  = 1'b0,
		REG_FIELD_CAPACITY = 1'b1
	} reg_idx_t;

	localparam int CFG_DATA_W = 9;
	localparam logic [1:0] TEXT_ENCODING_RST = 2'd0;
	localparam logic [8:0] FIELD_CAPACITY_RST = 9'd64;

	localparam int CODE_W = 21;
	localparam logic [CODE_W-1:0] CP_SPACE     = 21'h000020;
	localparam logic [CODE_W-1:0] CP_DEL       = 21'h00007F;
	localparam logic [CODE_W-1:0] CP_TWO_BYTE  = 21'h000080;
	localparam logic [CODE_W-1:0] CP_THREE_BYTE = 21'h000800;
	localparam logic [CODE_W-1:0] CP_FOUR_BYTE = 21'h010000;
	localparam logic [CODE_W-1:0] CP_SURR_LO   = 21'h00D800;
	localparam logic [CODE_W-1:0] CP_SURR_HI   = 21'h00DFFF;
	localparam logic [CODE_W-1:0] CP_MAX       = 21'h10FFFF;

	localparam logic [7:0] BOM_FF = 8'hFF;
	localparam logic [7:0] BOM_FE = 8'hFE;
	localparam logic [7:0] SPACES_MAX = 8'hFF;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// one decoded step of the text
	typedef struct packed {
		logic              code_valid;
		logic [CODE_W-1:0] code;
		cause_t            cause;
		logic              last;
	} ev_t;

endpackage

>>> sv/ttu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttu_front: byte decoder
// Accepts raw text bytes, decodes Latin-1, UTF-16 and UTF-8 into code points,
// detects NUL and malformed input and posts one event per useful byte.
// ----------------------------------------------------------------------------
module ttu_front import ttu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  enc_t       text_encoding,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       push,
	output ev_t        ev
);

	logic [2:0]        seq_position_q, seq_position_n;
	logic [2:0]        seq_expected_q, seq_expected_n;
	logic [CODE_W-1:0] partial_code_q, partial_code_n;
	logic [7:0]        held_unit_byte_q, held_unit_byte_n;
	logic [9:0]        high_half_q, high_half_n;
	logic              have_high_half_q, have_high_half_n;
	logic              msb_first_q, msb_first_n;
	logic              at_first_unit_q, at_first_unit_n;
	logic              halted_q, halted_n;

	always_comb begin
		logic              got;
		logic [CODE_W-1:0] code;
		cause_t            cause;
		logic [CODE_W-1:0] p;
		logic [CODE_W-1:0] floor_v;
		logic [2:0]        pos_inc;
		logic [15:0]       unit;
		logic              bom;

		seq_position_n   = seq_position_q;
		seq_expected_n   = seq_expected_q;
		partial_code_n   = partial_code_q;
		held_unit_byte_n = held_unit_byte_q;
		high_half_n      = high_half_q;
		have_high_half_n = have_high_half_q;
		msb_first_n      = msb_first_q;
		at_first_unit_n  = at_first_unit_q;
		got     = 1'b0;
		code    = '0;
		cause   = CAUSE_END;
		p       = '0;
		floor_v = '0;
		pos_inc = '0;
		unit    = '0;
		bom     = 1'b0;

		if (!halted_q) begin
			unique case (text_encoding)
				ENC_LATIN1: begin
					if (in_byte == 8'h00) cause = CAUSE_NUL;
					else begin
						got  = 1'b1;
						code = CODE_W'(in_byte);
					end
				end
				ENC_UTF8: begin
					if (seq_position_q == 3'd0) begin
						if (in_byte == 8'h00) cause = CAUSE_NUL;
						else if (!in_byte[7]) begin
							got  = 1'b1;
							code = CODE_W'(in_byte);
						end else if (in_byte[7:5] == 3'b110) begin
							seq_expected_n = 3'd2;
							partial_code_n = CODE_W'(in_byte[4:0]);
							seq_position_n = 3'd1;
						end else if (in_byte[7:4] == 4'b1110) begin
							seq_expected_n = 3'd3;
							partial_code_n = CODE_W'(in_byte[3:0]);
							seq_position_n = 3'd1;
						end else if (in_byte[7:3] == 5'b11110) begin
							seq_expected_n = 3'd4;
							partial_code_n = CODE_W'(in_byte[2:0]);
							seq_position_n = 3'd1;
						end else begin
							cause = CAUSE_INVALID;
						end
					end else if (in_byte[7:6] != 2'b10) begin
						cause = CAUSE_INVALID;
					end else begin
						p       = {partial_code_q[CODE_W-7:0], in_byte[5:0]};
						pos_inc = seq_position_q + 3'd1;
						if (pos_inc < seq_expected_q) begin
							partial_code_n = p;
							seq_position_n = pos_inc;
						end else begin
							seq_position_n = 3'd0;
							seq_expected_n = 3'd0;
							partial_code_n = '0;
							floor_v = (seq_expected_q == 3'd2) ? CP_TWO_BYTE :
								(seq_expected_q == 3'd3) ? CP_THREE_BYTE : CP_FOUR_BYTE;
							if (p > CP_MAX || (p >= CP_SURR_LO && p <= CP_SURR_HI) ||
								p < floor_v) begin
								cause = CAUSE_INVALID;
							end else begin
								got  = 1'b1;
								code = p;
							end
						end
					end
				end
				default: begin
					// UTF-16: first byte of a unit is held, second completes it
					if (seq_position_q == 3'd0) begin
						if (at_first_unit_q) msb_first_n = (text_encoding == ENC_UTF16BE);
						held_unit_byte_n = in_byte;
						seq_position_n   = 3'd1;
					end else begin
						seq_position_n = 3'd0;
						if (at_first_unit_q) begin
							at_first_unit_n = 1'b0;
							if (held_unit_byte_q == BOM_FF && in_byte == BOM_FE) begin
								msb_first_n = 1'b0;
								bom = 1'b1;
							end else if (held_unit_byte_q == BOM_FE && in_byte == BOM_FF) begin
								msb_first_n = 1'b1;
								bom = 1'b1;
							end
						end
						if (!bom) begin
							unit = msb_first_n ? {held_unit_byte_q, in_byte} :
								{in_byte, held_unit_byte_q};
							if (have_high_half_q) begin
								have_high_half_n = 1'b0;
								if (unit[15:10] != 6'b110111) cause = CAUSE_INVALID;
								else begin
									got  = 1'b1;
									code = CP_FOUR_BYTE + CODE_W'({high_half_q, unit[9:0]});
									high_half_n = '0;
								end
							end else if (unit == 16'h0000) begin
								cause = CAUSE_NUL;
							end else if (unit[15:10] == 6'b110110) begin
								high_half_n      = unit[9:0];
								have_high_half_n = 1'b1;
							end else if (unit[15:10] == 6'b110111) begin
								cause = CAUSE_INVALID;
							end else begin
								got  = 1'b1;
								code = CODE_W'(unit);
							end
						end
					end
				end
			endcase
		end

		halted_n = halted_q || (cause != CAUSE_END);

		// text ends in the middle of a sequence or surrogate pair
		if (last_byte && !halted_n) begin
			if (text_encoding == ENC_UTF8 && seq_position_n != 3'd0)
				cause = CAUSE_INVALID;
			else if ((text_encoding == ENC_UTF16LE || text_encoding == ENC_UTF16BE) &&
				have_high_half_n)
				cause = CAUSE_INVALID;
		end

		ev.code_valid = got;
		ev.code       = code;
		ev.cause      = cause;
		ev.last       = last_byte;
		push = accept && (got || cause != CAUSE_END || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_position_q   <= '0;
			seq_expected_q   <= '0;
			partial_code_q   <= '0;
			held_unit_byte_q <= '0;
			high_half_q      <= '0;
			have_high_half_q <= 1'b0;
			msb_first_q      <= 1'b0;
			at_first_unit_q  <= 1'b1;
			halted_q         <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				seq_position_q   <= '0;
				seq_expected_q   <= '0;
				partial_code_q   <= '0;
				held_unit_byte_q <= '0;
				high_half_q      <= '0;
				have_high_half_q <= 1'b0;
				msb_first_q      <= 1'b0;
				at_first_unit_q  <= 1'b1;
				halted_q         <= 1'b0;
			end else begin
				seq_position_q   <= seq_position_n;
				seq_expected_q   <= seq_expected_n;
				partial_code_q   <= partial_code_n;
				held_unit_byte_q <= held_unit_byte_n;
				high_half_q      <= high_half_n;
				have_high_half_q <= have_high_half_n;
				msb_first_q      <= msb_first_n;
				at_first_unit_q  <= at_first_unit_n;
				halted_q         <= halted_n;
			end
		end
	end

endmodule

>>> sv/ttu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttu_fifo: decode event queue
// Small register queue between the decoder and the encoder so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module ttu_fifo import ttu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ev_t  wr_ev,
	input  logic pop,
	output logic full,
	output logic rd_valid,
	output ev_t  rd_ev
);

	ev_t                   entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign full     = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_ev    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/ttu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttu_back: UTF-8 encoder and output stage
// Applies capacity, space holding and halting to decoded code points, encodes
// them as UTF-8 and drives the result register.
// ----------------------------------------------------------------------------
module ttu_back import ttu_pkg::*; #(
	parameter int MAX_CAPACITY = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [8:0] field_capacity,
	input  logic       ev_valid,
	input  ev_t        ev,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] lead_spaces,
	output logic [2:0] byte_count,
	output logic [7:0] utf8_byte0,
	output logic [7:0] utf8_byte1,
	output logic [7:0] utf8_byte2,
	output logic [7:0] utf8_byte3,
	output logic       text_end,
	output logic [1:0] stop_cause
);

	localparam int CAP_W = $clog2(MAX_CAPACITY + 1);
	localparam int SUM_W = ((CAP_W > 9) ? CAP_W : 9) + 1;

	logic [CAP_W-1:0] written_q, written_n;
	logic [7:0]       pending_q, pending_n;
	logic             seen_q, seen_n;
	logic             halted_q, halted_n;
	cause_t           reason_q, reason_n;

	logic [SUM_W-1:0] cap;
	logic             has_result;
	logic [2:0]       emit_n;
	logic [7:0]       lead_n;
	logic [7:0]       b0, b1, b2, b3;
	logic             out_valid_q;

	always_comb begin
		logic [SUM_W-1:0]  fc_ext;
		logic [SUM_W-1:0]  max_ext;
		logic [SUM_W-1:0]  need;
		logic [CODE_W-1:0] cp;
		logic [2:0]        n;

		fc_ext  = SUM_W'(field_capacity);
		max_ext = SUM_W'(MAX_CAPACITY);
		cap     = (fc_ext > max_ext) ? max_ext : fc_ext;

		// control codes and DEL print as spaces
		cp = (ev.code < CP_SPACE || ev.code == CP_DEL) ? CP_SPACE : ev.code;
		n  = (cp < CP_TWO_BYTE) ? 3'd1 : (cp < CP_THREE_BYTE) ? 3'd2 :
			(cp < CP_FOUR_BYTE) ? 3'd3 : 3'd4;
		need = SUM_W'(written_q) + SUM_W'(n) + SUM_W'(1);

		written_n = written_q;
		pending_n = pending_q;
		seen_n    = seen_q;
		halted_n  = halted_q;
		reason_n  = reason_q;
		emit_n    = 3'd0;
		lead_n    = 8'd0;

		if (!halted_q) begin
			if (ev.code_valid) begin
				if (need > cap) begin
					halted_n = 1'b1;
					reason_n = CAUSE_FULL;
				end else begin
					written_n = CAP_W'(SUM_W'(written_q) + SUM_W'(n));
					if (cp == CP_SPACE) begin
						if (seen_q && pending_q != SPACES_MAX) pending_n = pending_q + 8'd1;
					end else begin
						emit_n    = n;
						lead_n    = pending_q;
						pending_n = 8'd0;
						seen_n    = 1'b1;
					end
				end
			end else if (ev.cause != CAUSE_END) begin
				halted_n = 1'b1;
				reason_n = ev.cause;
			end
		end

		b0 = 8'd0;
		b1 = 8'd0;
		b2 = 8'd0;
		b3 = 8'd0;
		unique case (emit_n)
			3'd1: b0 = cp[7:0];
			3'd2: begin
				b0 = {3'b110, cp[10:6]};
				b1 = {2'b10, cp[5:0]};
			end
			3'd3: begin
				b0 = {4'b1110, cp[15:12]};
				b1 = {2'b10, cp[11:6]};
				b2 = {2'b10, cp[5:0]};
			end
			3'd4: begin
				b0 = {5'b11110, cp[20:18]};
				b1 = {2'b10, cp[17:12]};
				b2 = {2'b10, cp[11:6]};
				b3 = {2'b10, cp[5:0]};
			end
			default: ;
		endcase

		has_result = (emit_n != 3'd0) || ev.last;
	end

	assign pop = ev_valid && (!has_result || !out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			pending_q <= '0;
			seen_q    <= 1'b0;
			halted_q  <= 1'b0;
			reason_q  <= CAUSE_END;
		end else if (pop) begin
			if (ev.last) begin
				written_q <= '0;
				pending_q <= '0;
				seen_q    <= 1'b0;
				halted_q  <= 1'b0;
				reason_q  <= CAUSE_END;
			end else begin
				written_q <= written_n;
				pending_q <= pending_n;
				seen_q    <= seen_n;
				halted_q  <= halted_n;
				reason_q  <= reason_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_result) begin
			lead_spaces <= lead_n;
			byte_count  <= emit_n;
			utf8_byte0  <= b0;
			utf8_byte1  <= b1;
			utf8_byte2  <= b2;
			utf8_byte3  <= b3;
			text_end    <= ev.last;
			stop_cause  <= ev.last ? reason_n : CAUSE_END;
		end
	end

	assign out_valid = out_valid_q;

	a_cause_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stop_cause != CAUSE_END |-> text_end)
		else $error("stop cause on a result that does not end the text");

	a_empty_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && byte_count == 3'd0 |-> text_end && lead_spaces == 8'd0)
		else $error("empty result before end of text");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop && ev.last |=> written_q == '0 && !halted_q && pending_q == 8'd0)
		else $error("text state not cleared after last byte");

endmodule

>>> sv/tag_text_to_utf8_transcoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_text_to_utf8_transcoder_top: tag text to UTF-8 transcoder
// Decodes Latin-1, UTF-16 or UTF-8 text bytes and re-emits UTF-8 code points
// with capacity limiting, space trimming and a stop cause at text end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one raw text byte per transfer, last_byte set on
//   the final byte. Output channel carries at most one result per byte: one
//   for every emitted non-space code point and always one for the last byte.
//   The front end decodes each byte in the cycle it is accepted and queues a
//   decode event in a four-entry queue; the back end encodes one event per
//   cycle into the output register while out_stall is not holding a result
//   there. The event is written into the queue when the byte is accepted,
//   and the result register loads when the back end pops that event.
//   Sustained rate is one byte per cycle while out_stall stays low.
//   in_stall rises only when the event queue is full, which happens while
//   out_stall holds the output register and the queue fills behind it.
//   Configuration (text_encoding, field_capacity) is written through
//   cfg_wr_en/cfg_index/cfg_data while no transfer is in flight.
//   Reset sets Latin-1 and a capacity of 64 and clears all text state.
// ----------------------------------------------------------------------------
module tag_text_to_utf8_transcoder_top import ttu_pkg::*; #(
	parameter int MAX_CAPACITY = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            lead_spaces,
	output logic [2:0]            byte_count,
	output logic [7:0]            utf8_byte0,
	output logic [7:0]            utf8_byte1,
	output logic [7:0]            utf8_byte2,
	output logic [7:0]            utf8_byte3,
	output logic                  text_end,
	output logic [1:0]            stop_cause
);

	enc_t       text_encoding_q;
	logic [8:0] field_capacity_q;

	logic accept;
	logic push;
	ev_t  push_ev;
	logic fifo_full;
	logic fifo_valid;
	ev_t  head_ev;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_encoding_q  <= enc_t'(TEXT_ENCODING_RST);
			field_capacity_q <= FIELD_CAPACITY_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TEXT_ENCODING:  text_encoding_q  <= enc_t'(cfg_data[1:0]);
				REG_FIELD_CAPACITY: field_capacity_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;

	ttu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_encoding (text_encoding_q),
		.accept        (accept),
		.in_byte       (in_byte),
		.last_byte     (last_byte),
		.push          (push),
		.ev            (push_ev)
	);

	ttu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_ev    (push_ev),
		.pop      (pop),
		.full     (fifo_full),
		.rd_valid (fifo_valid),
		.rd_ev    (head_ev)
	);

	ttu_back #(
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.field_capacity (field_capacity_q),
		.ev_valid       (fifo_valid),
		.ev             (head_ev),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.lead_spaces    (lead_spaces),
		.byte_count     (byte_count),
		.utf8_byte0     (utf8_byte0),
		.utf8_byte1     (utf8_byte1),
		.utf8_byte2     (utf8_byte2),
		.utf8_byte3     (utf8_byte3),
		.text_end       (text_end),
		.stop_cause     (stop_cause)
	);

endmodule

>>> verif/tag_text_to_utf8_transcoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_text_to_utf8_transcoder_top_tb: self-checking bench for the transcoder
// Feeds Latin-1, UTF-16 and UTF-8 texts a byte per transfer, predicts every
// UTF-8 result, the held space count and the stop cause, and checks each one
// in order. Runs a short directed set, then random texts over several
// register settings and several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module tag_text_to_utf8_transcoder_top_tb;
	import ttu_pkg::*;

	localparam int MAX_CAPACITY   = 256;
	localparam int PHASE_ITEMS    = 115;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [8:0] CAP_RANDOM = 9'd0;

	localparam enc_t PHASE_ENC [9] = '{ENC_UTF8, ENC_UTF16LE, ENC_UTF16BE, ENC_LATIN1,
		ENC_UTF8, ENC_UTF16LE, ENC_UTF16BE, ENC_LATIN1, ENC_UTF8};
	// 511 checks the clamp to MAX_CAPACITY
	localparam logic [8:0] PHASE_CAP [9] = '{9'd256, 9'd64, 9'd16, 9'd2,
		CAP_RANDOM, 9'd511, 9'd256, 9'd256, 9'd24};

	typedef struct packed {
		logic [7:0]      lead;
		logic [2:0]      count;
		logic [3:0][7:0] bytes;
		logic            text_end;
		cause_t          cause;
	} utf8_result_t;

	class transcode_scoreboard;
		enc_t         encoding;
		logic [8:0]   capacity;
		logic [2:0]   seq_pos;
		logic [2:0]   seq_len;
		logic [20:0]  partial;
		logic [7:0]   held_byte;
		logic [9:0]   high_half;
		logic         have_high;
		logic         msb_first;
		logic         first_unit;
		int unsigned  written;
		logic [7:0]   pending;
		logic         seen_text;
		logic         halted;
		cause_t       reason;
		utf8_result_t utf8_results_due[$];
		int           errors;

		function new();
			encoding = enc_t'(TEXT_ENCODING_RST);
			capacity = FIELD_CAPACITY_RST;
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			seq_pos = '0;
			seq_len = '0;
			partial = '0;
			held_byte = '0;
			high_half = '0;
			have_high = 1'b0;
			msb_first = 1'b0;
			first_unit = 1'b1;
			written = 0;
			pending = '0;
			seen_text = 1'b0;
			halted = 1'b0;
			reason = CAUSE_END;
		endfunction

		function void write_reg(input reg_idx_t idx, input logic [8:0] value);
			case (idx)
				REG_TEXT_ENCODING: encoding = enc_t'(value[1:0]);
				default: capacity = value;
			endcase
		endfunction

		function void stop_text(input cause_t cause);
			halted = 1'b1;
			reason = cause;
		endfunction

		// returns the UTF-8 length put out, 0 when held, dropped or out of room
		function int emit_code(input logic [20:0] code_in, output logic [3:0][7:0] bytes);
			int unsigned cap;
			int unsigned len;
			logic [20:0] code;
			bytes = '0;
			code = (code_in < CP_SPACE || code_in == CP_DEL) ? CP_SPACE : code_in;
			len = code < CP_TWO_BYTE ? 1 : code < CP_THREE_BYTE ? 2 : code < CP_FOUR_BYTE ? 3 : 4;
			cap = capacity > MAX_CAPACITY ? MAX_CAPACITY : capacity;
			if (written + len + 1 > cap) begin
				stop_text(CAUSE_FULL);
				return 0;
			end
			written += len;
			if (code == CP_SPACE) begin
				if (seen_text && pending != SPACES_MAX)
					pending++;
				return 0;
			end
			seen_text = 1'b1;
			case (len)
				1: bytes[0] = code[7:0];
				2: begin
					bytes[0] = {3'b110, code[10:6]};
					bytes[1] = {2'b10, code[5:0]};
				end
				3: begin
					bytes[0] = {4'b1110, code[15:12]};
					bytes[1] = {2'b10, code[11:6]};
					bytes[2] = {2'b10, code[5:0]};
				end
				default: begin
					bytes[0] = {5'b11110, code[20:18]};
					bytes[1] = {2'b10, code[17:12]};
					bytes[2] = {2'b10, code[11:6]};
					bytes[3] = {2'b10, code[5:0]};
				end
			endcase
			return len;
		endfunction

		function bit decode_utf8(input logic [7:0] c, output logic [20:0] code);
			logic [20:0] min_code;
			code = '0;
			if (seq_pos == 0) begin
				if (c == 8'h00) begin
					stop_text(CAUSE_NUL);
					return 0;
				end
				if (c < 8'h80) begin
					code = {13'd0, c};
					return 1;
				end
				if ((c & 8'hE0) == 8'hC0) begin
					seq_len = 3'd2;
					partial = {16'd0, c[4:0]};
				end else if ((c & 8'hF0) == 8'hE0) begin
					seq_len = 3'd3;
					partial = {17'd0, c[3:0]};
				end else if ((c & 8'hF8) == 8'hF0) begin
					seq_len = 3'd4;
					partial = {18'd0, c[2:0]};
				end else begin
					stop_text(CAUSE_INVALID);
					return 0;
				end
				seq_pos = 3'd1;
				return 0;
			end
			if ((c & 8'hC0) != 8'h80) begin
				stop_text(CAUSE_INVALID);
				return 0;
			end
			partial = {partial[14:0], c[5:0]};
			seq_pos++;
			if (seq_pos < seq_len)
				return 0;
			// a length left over from UTF-16 counts as a four byte form
			min_code = seq_len == 2 ? CP_TWO_BYTE : seq_len == 3 ? CP_THREE_BYTE : CP_FOUR_BYTE;
			code = partial;
			seq_pos = '0;
			seq_len = '0;
			partial = '0;
			if (code > CP_MAX || (code >= CP_SURR_LO && code <= CP_SURR_HI) || code < min_code) begin
				stop_text(CAUSE_INVALID);
				code = '0;
				return 0;
			end
			return 1;
		endfunction

		function bit decode_utf16(input logic [7:0] c, output logic [20:0] code);
			logic [15:0] unit;
			logic [7:0]  b0;
			code = '0;
			if (seq_pos == 0) begin
				if (first_unit)
					msb_first = (encoding == ENC_UTF16BE);
				held_byte = c;
				seq_pos = 3'd1;
				return 0;
			end
			seq_pos = '0;
			b0 = held_byte;
			if (first_unit) begin
				first_unit = 1'b0;
				if (b0 == BOM_FF && c == BOM_FE) begin
					msb_first = 1'b0;
					return 0;
				end
				if (b0 == BOM_FE && c == BOM_FF) begin
					msb_first = 1'b1;
					return 0;
				end
			end
			unit = msb_first ? {b0, c} : {c, b0};
			if (have_high) begin
				have_high = 1'b0;
				if (unit < 16'hDC00 || unit > 16'hDFFF) begin
					stop_text(CAUSE_INVALID);
					return 0;
				end
				code = CP_FOUR_BYTE + {high_half, 10'd0} + (unit - 16'hDC00);
				high_half = '0;
				return 1;
			end
			if (unit == 16'h0000) begin
				stop_text(CAUSE_NUL);
				return 0;
			end
			if (unit >= 16'hD800 && unit < 16'hDC00) begin
				high_half = unit[9:0];
				have_high = 1'b1;
				return 0;
			end
			if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
				stop_text(CAUSE_INVALID);
				return 0;
			end
			code = {5'd0, unit};
			return 1;
		endfunction

		function void take_text_byte(input logic [7:0] c, input logic last);
			utf8_result_t    r;
			logic [20:0]     code;
			logic [3:0][7:0] bytes;
			bit              got;
			int              len;
			r = '0;
			code = '0;
			bytes = '0;
			got = 0;
			len = 0;
			if (!halted) begin
				case (encoding)
					ENC_LATIN1: begin
						if (c == 8'h00)
							stop_text(CAUSE_NUL);
						else begin
							code = {13'd0, c};
							got = 1;
						end
					end
					ENC_UTF8: got = decode_utf8(c, code);
					default: got = decode_utf16(c, code);
				endcase
				if (got) begin
					len = emit_code(code, bytes);
					if (len > 0) begin
						r.lead = pending;
						pending = '0;
					end
				end
			end
			// unfinished sequence at the end of the text
			if (last && !halted) begin
				if (encoding == ENC_UTF8 && seq_pos != 0)
					stop_text(CAUSE_INVALID);
				else if ((encoding == ENC_UTF16LE || encoding == ENC_UTF16BE) && have_high)
					stop_text(CAUSE_INVALID);
			end
			if (len == 0 && !last)
				return;
			r.count = 3'(len);
			r.bytes = bytes;
			r.text_end = last;
			r.cause = last ? reason : CAUSE_END;
			utf8_results_due.push_back(r);
			if (last)
				clear_text();
		endfunction

		function void compare_field(input string name, input logic [7:0] want,
				input logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_utf8_result(input utf8_result_t got);
			utf8_result_t want;
			if (utf8_results_due.size() == 0) begin
				$error("result with nothing expected: byte_count %0d text_end %0b",
					got.count, got.text_end);
				errors++;
				return;
			end
			want = utf8_results_due.pop_front();
			compare_field("lead_spaces", want.lead, got.lead);
			compare_field("byte_count", 8'(want.count), 8'(got.count));
			compare_field("utf8_byte0", want.bytes[0], got.bytes[0]);
			compare_field("utf8_byte1", want.bytes[1], got.bytes[1]);
			compare_field("utf8_byte2", want.bytes[2], got.bytes[2]);
			compare_field("utf8_byte3", want.bytes[3], got.bytes[3]);
			compare_field("text_end", 8'(want.text_end), 8'(got.text_end));
			compare_field("stop_cause", 8'(want.cause), 8'(got.cause));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic                  cfg_index = REG_TEXT_ENCODING;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_byte = '0;
	logic                  last_byte = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            lead_spaces;
	logic [2:0]            byte_count;
	logic [7:0]            utf8_byte0;
	logic [7:0]            utf8_byte1;
	logic [7:0]            utf8_byte2;
	logic [7:0]            utf8_byte3;
	logic                  text_end;
	logic [1:0]            stop_cause;

	transcode_scoreboard sb;
	logic [8:0]          text_q[$];
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  idle_cycles = 0;

	tag_text_to_utf8_transcoder_top #(
		.MAX_CAPACITY(MAX_CAPACITY)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lead_spaces(lead_spaces),
		.byte_count (byte_count),
		.utf8_byte0 (utf8_byte0),
		.utf8_byte1 (utf8_byte1),
		.utf8_byte2 (utf8_byte2),
		.utf8_byte3 (utf8_byte3),
		.text_end   (text_end),
		.stop_cause (stop_cause)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// transfer monitor: predict on every accepted byte, check every result
	always @(posedge clk) begin
		utf8_result_t r;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_text_byte(in_byte, last_byte);
			if (out_valid && !out_stall) begin
				r.lead = lead_spaces;
				r.count = byte_count;
				r.bytes = {utf8_byte3, utf8_byte2, utf8_byte1, utf8_byte0};
				r.text_end = text_end;
				r.cause = cause_t'(stop_cause);
				sb.check_utf8_result(r);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("** tag_text_to_utf8_transcoder_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_queue();
		logic [8:0] item;
		while (text_q.size() != 0) begin
			item = text_q.pop_front();
			send_byte(item[7:0], item[8]);
		end
	endtask

	// hold the sender until every result is in and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.utf8_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input enc_t enc, input logic [8:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TEXT_ENCODING;
		cfg_data <= {7'd0, enc};
		@(posedge clk);
		sb.write_reg(REG_TEXT_ENCODING, {7'd0, enc});
		cfg_index <= REG_FIELD_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		sb.write_reg(REG_FIELD_CAPACITY, cap);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct <= 0;
			end
			1: begin
				send_idle_pct = 50;
				stall_pct <= 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct <= 50;
			end
			default: begin
				send_idle_pct = 21;
				stall_pct <= 21;
			end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b);
		text_q.push_back({1'b0, b});
	endtask

	// UTF-8 form of cp in exactly len bytes, so overlong forms come out too
	task automatic push_utf8_len(input logic [20:0] cp, input int len);
		case (len)
			1: push_byte(cp[7:0]);
			2: begin
				push_byte({3'b110, cp[10:6]});
				push_byte({2'b10, cp[5:0]});
			end
			3: begin
				push_byte({4'b1110, cp[15:12]});
				push_byte({2'b10, cp[11:6]});
				push_byte({2'b10, cp[5:0]});
			end
			default: begin
				push_byte({5'b11110, cp[20:18]});
				push_byte({2'b10, cp[17:12]});
				push_byte({2'b10, cp[11:6]});
				push_byte({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic push_unit(input bit be, input logic [15:0] u);
		if (be) begin
			push_byte(u[15:8]);
			push_byte(u[7:0]);
		end else begin
			push_byte(u[7:0]);
			push_byte(u[15:8]);
		end
	endtask

	function automatic logic [20:0] pick_code();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35)
			return 21'($urandom_range(21'h21, 21'h7E));
		if (sel < 50)
			return CP_SPACE;
		if (sel < 55)
			return ($urandom_range(3) == 0) ? CP_DEL : 21'($urandom_range(1, 31));
		if (sel < 68)
			return 21'($urandom_range(21'h80, 21'h7FF));
		if (sel < 82)
			return $urandom_range(1) ? 21'($urandom_range(21'h800, 21'hD7FF))
				: 21'($urandom_range(21'hE000, 21'hFFFF));
		if (sel < 99)
			return 21'($urandom_range(21'h10000, CP_MAX));
		return 21'h0;
	endfunction

	task automatic make_utf8(input int n_codes);
		logic [20:0] cp;
		logic [7:0]  b;
		for (int i = 0; i < n_codes; i++) begin
			cp = pick_code();
			if ($urandom_range(99) >= 5) begin
				push_utf8_len(cp, cp < CP_TWO_BYTE ? 1 : cp < CP_THREE_BYTE ? 2
					: cp < CP_FOUR_BYTE ? 3 : 4);
			end else begin
				b = 8'($urandom_range(255));
				case ($urandom_range(6))
					0: push_utf8_len(21'($urandom_range(0, 21'h7F)), 2);
					1: push_utf8_len(21'($urandom_range(0, 21'h7FF)), 3);
					2: push_utf8_len(21'($urandom_range(0, 21'hFFFF)), 4);
					3: push_utf8_len(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
					4: push_utf8_len(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
					5: begin
						// lead without a proper continuation
						push_byte({3'b110, b[4:0]});
						if ($urandom_range(1))
							push_byte(b[7:6] == 2'b10 ? {1'b0, b[6:0]} : b);
					end
					default: push_byte($urandom_range(1) ? {2'b10, b[5:0]} : {5'b11111, b[2:0]});
				endcase
			end
		end
	endtask

	task automatic make_utf16(input bit be_cfg, input int n_codes);
		bit          be;
		logic [20:0] cp;
		logic [19:0] sup;
		int unsigned sel;
		be = be_cfg;
		case ($urandom_range(3))
			0: begin
				push_byte(BOM_FF);
				push_byte(BOM_FE);
				be = 1'b0;
			end
			1: begin
				push_byte(BOM_FE);
				push_byte(BOM_FF);
				be = 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < n_codes; i++) begin
			cp = pick_code();
			sup = 20'(cp - CP_FOUR_BYTE);
			sel = $urandom_range(99);
			if (sel < 2) begin
				push_unit(be, 16'($urandom_range(16'hDC00, 16'hDFFF)));
			end else if (sel < 4) begin
				push_unit(be, 16'($urandom_range(16'hD800, 16'hDBFF)));
				push_unit(be, 16'($urandom_range(16'h0001, 16'hDBFF)));
			end else if (sel < 6) begin
				push_unit(be, 16'($urandom_range(16'hD800, 16'hDBFF)));
			end else if (sel < 7) begin
				push_byte(8'($urandom_range(255)));
			end else if (cp >= CP_FOUR_BYTE) begin
				push_unit(be, {6'b110110, sup[19:10]});
				push_unit(be, {6'b110111, sup[9:0]});
			end else begin
				push_unit(be, cp[15:0]);
			end
		end
	endtask

	// one text: mostly well formed with random content, some raw noise
	task automatic make_text(input enc_t enc);
		int unsigned sel;
		int          n_codes;
		logic [20:0] cp;
		logic [8:0]  item;
		sel = $urandom_range(99);
		if (sel < 12) begin
			repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
		end else begin
			n_codes = (sel < 20) ? $urandom_range(40, 90) : $urandom_range(1, 10);
			case (enc)
				ENC_LATIN1: begin
					repeat (n_codes) begin
						cp = pick_code();
						push_byte(cp[7:0]);
					end
				end
				ENC_UTF8: make_utf8(n_codes);
				default: make_utf16(enc == ENC_UTF16BE, n_codes);
			endcase
		end
		item = text_q.pop_back();
		text_q.push_back({1'b1, item[7:0]});
	endtask

	initial begin
		logic [8:0] item;
		logic [8:0] cap;
		int         sent;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Latin-1: leading space dropped, control and DEL held as spaces,
		// trailing space discarded; then NUL halts the rest of the text
		set_config(ENC_LATIN1, FIELD_CAPACITY_RST);
		text_q = '{9'h020, 9'h041, 9'h009, 9'h07F, 9'h0FF, 9'h120, 9'h042, 9'h000, 9'h143};
		send_queue();
		// UTF-8: highest code point, then an unfinished sequence at the end
		settle();
		set_config(ENC_UTF8, FIELD_CAPACITY_RST);
		text_q = '{9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h1C3};
		send_queue();
		// UTF-16BE register overridden by a little endian mark, a surrogate
		// pair, then an odd trailing byte
		settle();
		set_config(ENC_UTF16BE, FIELD_CAPACITY_RST);
		text_q = '{9'h0FF, 9'h0FE, 9'h03D, 9'h0D8, 9'h000, 9'h0DE, 9'h141};
		send_queue();
		// smallest capacity: one byte fits, the next one fills it
		settle();
		set_config(ENC_LATIN1, 9'd2);
		text_q = '{9'h041, 9'h142};
		send_queue();

		foreach (PHASE_ENC[p]) begin
			settle();
			cap = (PHASE_CAP[p] == CAP_RANDOM) ? 9'($urandom_range(2, MAX_CAPACITY))
				: PHASE_CAP[p];
			set_config(PHASE_ENC[p], cap);
			set_idling(p % 4);
			// a text cut at the end of a phase runs on under the next setting
			text_q.delete();
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (text_q.size() == 0)
					make_text(PHASE_ENC[p]);
				item = text_q.pop_front();
				send_byte(item[7:0], item[8]);
				sent++;
				if (p == 1 && sent == PHASE_ITEMS / 2)
					settle();
			end
		end

		settle();
		if (sb.utf8_results_due.size() != 0) begin
			$error("%0d expected results never arrived", sb.utf8_results_due.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("** tag_text_to_utf8_transcoder_top: PASSED **");
		end else begin
			$display("** tag_text_to_utf8_transcoder_top: FAILED **");
		end
		$finish;
	end

endmodule
